// ===== rtl/smpq_pkg.sv =====
package smpq_pkg;

    localparam int DEF_CAPACITY = 16;
    localparam int VALUE_W      = 32;
    localparam int COUNT_OUT_W  = 5;

    localparam logic [1:0] MODE_PUSH  = 2'd0;
    localparam logic [1:0] MODE_POP   = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    localparam logic signed [VALUE_W-1:0] EMPTY_TOP = -32'sd1;

    typedef logic signed [VALUE_W-1:0] value_t;

    typedef struct packed {
        logic   push;
        logic   pop;
        value_t value;
    } cell_ctrl_t;

endpackage

// ===== rtl/sorted_min_priority_queue_top.sv =====
// Channel  Transfer when      Ports
// -------  -----------------  ------------------------------------------------
// request  start && !busy    mode, value
// result   done              top_value, is_empty, entry_count, push_dropped
//
// One request per cycle; busy stays low. Every cell of the sorted row updates
// in the transfer cycle, and the result strobes done in the following cycle.
// Reset empties the queue at once; cell contents are held until overwritten.
// The result is shown for one cycle only; the receiver cannot stall it.
module sorted_min_priority_queue_top
    import smpq_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    mode,
    input  logic signed [VALUE_W-1:0]     value,
    output logic                          done,
    output logic signed [VALUE_W-1:0]     top_value,
    output logic                          is_empty,
    output logic [COUNT_OUT_W-1:0]        entry_count,
    output logic                          push_dropped
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             done_reg;
    logic             dropped_reg;
    logic             dropped_next;
    logic             full;
    logic             accept;
    cell_ctrl_t       ctrl;

    value_t           cell_value [CAPACITY];
    logic [CAPACITY-1:0] cell_gt;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (count_reg == CNT_W'(CAPACITY));

    assign ctrl.push  = accept && (mode == MODE_PUSH) && !full;
    assign ctrl.pop   = accept && (mode == MODE_POP) && (count_reg != '0);
    assign ctrl.value = value;

    always_comb
    begin
        count_next   = count_reg;
        dropped_next = 1'b0;
        if (accept)
        begin
            case (mode)
                MODE_PUSH:
                begin
                    if (full)
                    begin
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                MODE_POP:
                begin
                    if (count_reg != '0)
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                MODE_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            done_reg    <= 1'b0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            done_reg    <= accept;
            dropped_reg <= dropped_next;
        end
    end

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            value_t left_value;
            logic   left_gt;
            value_t right_value;

            if (i == 0)
            begin : g_first
                assign left_value = '0;
                assign left_gt    = 1'b0;
            end
            else
            begin : g_mid
                assign left_value = cell_value[i-1];
                assign left_gt    = cell_gt[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_last
                assign right_value = '0;
            end
            else
            begin : g_inner
                assign right_value = cell_value[i+1];
            end

            smpq_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .occupied    (count_reg > CNT_W'(i)),
                .left_value  (left_value),
                .left_gt     (left_gt),
                .right_value (right_value),
                .value       (cell_value[i]),
                .gt          (cell_gt[i])
            );
        end
    endgenerate

    assign done         = done_reg;
    assign is_empty     = (count_reg == '0);
    assign top_value    = (count_reg == '0) ? EMPTY_TOP : cell_value[0];
    assign entry_count  = COUNT_OUT_W'(count_reg);
    assign push_dropped = dropped_reg;

endmodule

// ===== rtl/smpq_cell.sv =====
module smpq_cell
    import smpq_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  logic       occupied,
    input  value_t     left_value,
    input  logic       left_gt,
    input  value_t     right_value,
    output value_t     value,
    output logic       gt
);

    value_t value_reg;
    value_t value_next;

    assign gt    = !occupied || (value_reg > ctrl.value);
    assign value = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.push && gt)
        begin
            if (left_gt)
            begin
                value_next = left_value;
            end
            else
            begin
                value_next = ctrl.value;
            end
        end
        else if (ctrl.pop)
        begin
            value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule
